FILE: hw/rtl/dct4_pkg.sv
// Shared widths, constants, types and butterfly term tables for the 4x4 forward DCT.
package dct4_pkg;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 22;
	localparam int POS_W    = 4;

	// Block geometry
	localparam int DIM      = 4;
	localparam int DIM_W    = 2;
	localparam int BLK_N    = DIM * DIM;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLK_N - 1);

	// Arithmetic widths: butterfly operand, constant, product, rounding sum
	localparam int OP_W     = 22;
	localparam int K_W      = 15;
	localparam int PROD_W   = OP_W + K_W;
	localparam int ACC_W    = PROD_W + 1;
	localparam int RND_SH   = 13;
	localparam int RND_HALF = 1 << (RND_SH - 1);

	// Butterfly constants
	localparam logic signed [K_W-1:0] K_A   = K_W'(5793);
	localparam logic signed [K_W-1:0] K_B   = K_W'(3135);
	localparam logic signed [K_W-1:0] K_C   = K_W'(7568);
	localparam logic signed [K_W-1:0] K_A_N = K_W'(-5793);
	localparam logic signed [K_W-1:0] K_C_N = K_W'(-7568);

	// Operand select codes for one butterfly term
	localparam logic [1:0] SEL_S0 = 2'd0;
	localparam logic [1:0] SEL_S1 = 2'd1;
	localparam logic [1:0] SEL_D0 = 2'd2;
	localparam logic [1:0] SEL_D1 = 2'd3;

	// Block queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef sample_t [BLK_N-1:0] block_t;

	// One complete block moving between front, queue and back
	typedef struct packed {
		logic   valid;
		block_t data;
	} blk_req_t;

	// Term j of a butterfly: outputs y0,y1,y2,y3 each take terms 2k and 2k+1
	function automatic logic [1:0] term_sel(input logic [2:0] j);
		logic [1:0] sel;
		case (j)
			3'd0: sel = SEL_S0;
			3'd1: sel = SEL_S1;
			3'd2: sel = SEL_D0;
			3'd3: sel = SEL_D1;
			3'd4: sel = SEL_S0;
			3'd5: sel = SEL_S1;
			3'd6: sel = SEL_D1;
			3'd7: sel = SEL_D0;
			default: sel = SEL_S0;
		endcase
		return sel;
	endfunction

	function automatic logic signed [K_W-1:0] term_coef(input logic [2:0] j);
		logic signed [K_W-1:0] k;
		case (j)
			3'd0: k = K_A;
			3'd1: k = K_A;
			3'd2: k = K_B;
			3'd3: k = K_C;
			3'd4: k = K_A;
			3'd5: k = K_A_N;
			3'd6: k = K_B;
			3'd7: k = K_C_N;
			default: k = K_A;
		endcase
		return k;
	endfunction

endpackage

FILE: hw/rtl/dct4_if.sv
// Handshake channels for residual samples and transform coefficients.
interface dct4_sample_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [dct4_pkg::SAMPLE_W-1:0]   sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface dct4_coef_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [dct4_pkg::COEF_W-1:0]     coefficient;
	logic [dct4_pkg::POS_W-1:0]             position;
	logic                                   last;

	modport source(output valid, output coefficient, output position, output last,
		input ready);
	modport sink(input valid, input coefficient, input position, input last,
		output ready);
endinterface

FILE: hw/rtl/dct4x4_forward_transform.sv
// Top level of the 4x4 forward DCT: sample front end, block queue, transform engine.
//
// samples: one signed 16-bit residual sample per request, blocks of sixteen in
//   raster order (row by row). Ready drops only while the sixteenth sample of a
//   block is due and both queue entries are occupied.
// coefs: sixteen requests per block, coefficient (signed 22-bit), position
//   (column*4+row, 0 to 15 in order) and last on position 15.
// Sequence: once the sixteenth sample is accepted, the block is taken from the
//   queue, then eight butterflies run on one shared 22x15 multiplier, and then
//   the first coefficient is valid.
// Throughput: one block at a time, set by the serial multiplier and the emission;
//   the engine takes no new block until its last coefficient is accepted, while
//   from idle a burst of up to 63 samples is taken at one per cycle (one block in
//   the engine, two queued, fifteen of the next).
// Reset (arst_n low) drops the partial block, empties the queue and aborts any
//   transform or emission in progress.
// A stall on coefs holds the current coefficient; the front end keeps taking
//   samples until the queue is full and the sixteenth sample of a block is due.
module dct4x4_forward_transform (
	input  logic         clk,
	input  logic         arst_n,
	dct4_sample_if.sink  samples,
	dct4_coef_if.source  coefs
);

	dct4_pkg::blk_req_t push;
	dct4_pkg::blk_req_t head;
	logic               q_full;
	logic               pop;

	dct4_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.q_full  (q_full),
		.push    (push)
	);

	dct4_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	dct4_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.coefs  (coefs)
	);

endmodule

FILE: hw/rtl/dct4_front.sv
// Front end: collects sixteen raster-order samples and pushes each full block.
module dct4_front (
	input  logic               clk,
	input  logic               arst_n,
	dct4_sample_if.sink        samples,
	input  logic               q_full,
	output dct4_pkg::blk_req_t push
);

	logic [dct4_pkg::POS_W-1:0] fill_q;
	dct4_pkg::sample_t          smp_q [dct4_pkg::BLK_N-1];
	logic                       accept;
	logic                       blk_done;

	// Only the sample that closes a block needs queue space
	assign blk_done      = (fill_q == dct4_pkg::POS_LAST);
	assign samples.ready = !(blk_done && q_full);
	assign accept        = samples.valid && samples.ready;

	// Block push: fifteen held samples plus the one arriving now
	always_comb begin
		push.valid = accept && blk_done;
		for (int i = 0; i < dct4_pkg::BLK_N - 1; i++) begin
			push.data[i] = smp_q[i];
		end
		push.data[dct4_pkg::BLK_N-1] = samples.sample;
	end

	// Fill count wraps at sixteen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	// Sample shift line, oldest at index 0
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < dct4_pkg::BLK_N - 2; i++) begin
				smp_q[i] <= smp_q[i+1];
			end
			smp_q[dct4_pkg::BLK_N-2] <= samples.sample;
		end
	end

endmodule

FILE: hw/rtl/dct4_queue.sv
// Two-entry block queue between the sample front end and the transform engine.
module dct4_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  dct4_pkg::blk_req_t push,
	input  logic               pop,
	output logic               full,
	output dct4_pkg::blk_req_t head
);

	dct4_pkg::block_t            ent_q [dct4_pkg::QDEPTH];
	logic [dct4_pkg::QPTR_W-1:0] wr_q;
	logic [dct4_pkg::QPTR_W-1:0] rd_q;
	logic [dct4_pkg::QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == dct4_pkg::QCNT_W'(dct4_pkg::QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.data  = ent_q[rd_q];

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push.valid && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			ent_q[wr_q] <= push.data;
		end
	end

	// Front end must never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (!full || pop))
		else $error("block pushed into full queue");

endmodule

FILE: hw/rtl/dct4_back.sv
// Transform engine: column then row butterflies on one shared multiplier, then emission.
module dct4_back (
	input  logic               clk,
	input  logic               arst_n,
	input  dct4_pkg::blk_req_t head,
	output logic               pop,
	dct4_coef_if.source        coefs
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	// Butterfly sequence: load, eight products, last rounding write
	localparam logic [3:0] STEP_LOAD      = 4'd0;
	localparam logic [3:0] STEP_FIRST_MUL = 4'd1;
	localparam logic [3:0] STEP_FIRST_ACC = 4'd2;
	localparam logic [3:0] STEP_LAST      = 4'd9;
	localparam logic [2:0] BFLY_LAST      = 3'd7;

	logic [1:0]                        state_q;
	logic [3:0]                        step_q;
	logic [2:0]                        bfly_q;
	logic [dct4_pkg::POS_W-1:0]        emit_q;

	dct4_pkg::sample_t                 blk_q [dct4_pkg::DIM][dct4_pkg::DIM];
	logic signed [dct4_pkg::COEF_W-1:0] mid_q [dct4_pkg::DIM][dct4_pkg::DIM];
	logic signed [dct4_pkg::COEF_W-1:0] res_q [dct4_pkg::DIM][dct4_pkg::DIM];
	logic signed [dct4_pkg::OP_W-1:0]  sd_q  [4];
	logic signed [dct4_pkg::PROD_W-1:0] prod_s1;
	logic signed [dct4_pkg::PROD_W-1:0] acc_q;

	logic                              in_calc;
	logic                              row_pass;
	logic                              out_acc;
	logic signed [dct4_pkg::OP_W-1:0]  x [dct4_pkg::DIM];
	logic [2:0]                        j_mul;
	logic [2:0]                        j_acc;
	logic [dct4_pkg::DIM_W-1:0]        k_out;
	logic signed [dct4_pkg::OP_W-1:0]  op;
	logic signed [dct4_pkg::ACC_W-1:0] sum;
	logic signed [dct4_pkg::ACC_W-1:0] rnd;
	logic signed [dct4_pkg::COEF_W-1:0] y;

	assign in_calc  = (state_q == ST_CALC);
	assign row_pass = bfly_q[2];
	assign pop      = (state_q == ST_IDLE) && head.valid;
	assign out_acc  = coefs.valid && coefs.ready;

	assign coefs.valid       = (state_q == ST_EMIT);
	assign coefs.coefficient = res_q[0][0];
	assign coefs.position    = emit_q;
	assign coefs.last        = (emit_q == dct4_pkg::POS_LAST);

	// Butterfly inputs: column 0 of the block scaled by 4, or row 0 of column results
	always_comb begin
		for (int r = 0; r < dct4_pkg::DIM; r++) begin
			if (row_pass) begin
				x[r] = mid_q[0][r];
			end else begin
				x[r] = dct4_pkg::OP_W'($signed(blk_q[r][0])) <<< 2;
			end
		end
	end

	// Term select for the multiplier and the accumulator
	assign j_mul = 3'(step_q - STEP_FIRST_MUL);
	assign j_acc = 3'(step_q - STEP_FIRST_ACC);
	assign k_out = j_acc[2:1];

	always_comb begin
		case (dct4_pkg::term_sel(j_mul))
			dct4_pkg::SEL_S0: op = sd_q[0];
			dct4_pkg::SEL_S1: op = sd_q[1];
			dct4_pkg::SEL_D0: op = sd_q[2];
			dct4_pkg::SEL_D1: op = sd_q[3];
			default:          op = sd_q[0];
		endcase
	end

	// Second term sum with half added, then floor shift
	assign sum = dct4_pkg::ACC_W'(acc_q) + dct4_pkg::ACC_W'(prod_s1)
		+ dct4_pkg::ACC_W'(dct4_pkg::RND_HALF);
	assign rnd = sum >>> dct4_pkg::RND_SH;
	assign y   = rnd[dct4_pkg::COEF_W-1:0];

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_LOAD;
			bfly_q  <= '0;
			emit_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						state_q <= ST_CALC;
						step_q  <= STEP_LOAD;
						bfly_q  <= '0;
					end
				end
				ST_CALC: begin
					if (step_q == STEP_LAST) begin
						step_q <= STEP_LOAD;
						bfly_q <= bfly_q + 1'b1;
						if (bfly_q == BFLY_LAST) begin
							state_q <= ST_EMIT;
							emit_q  <= '0;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						emit_q <= emit_q + 1'b1;
						if (emit_q == dct4_pkg::POS_LAST) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Multiplier stage
	always_ff @(posedge clk) begin
		prod_s1 <= dct4_pkg::PROD_W'(op) * dct4_pkg::PROD_W'(dct4_pkg::term_coef(j_mul));
	end

	// Block, butterfly sums, column and row results
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int r = 0; r < dct4_pkg::DIM; r++) begin
				for (int c = 0; c < dct4_pkg::DIM; c++) begin
					blk_q[r][c] <= head.data[r*dct4_pkg::DIM+c];
				end
			end
		end

		// Load sums and rotate the source so the next column or row sits at place 0
		if (in_calc && step_q == STEP_LOAD) begin
			sd_q[0] <= x[0] + x[3];
			sd_q[1] <= x[1] + x[2];
			sd_q[2] <= x[1] - x[2];
			sd_q[3] <= x[0] - x[3];
			if (row_pass) begin
				for (int r = 0; r < dct4_pkg::DIM; r++) begin
					mid_q[r] <= mid_q[(r+1)%dct4_pkg::DIM];
				end
			end else begin
				for (int r = 0; r < dct4_pkg::DIM; r++) begin
					for (int c = 0; c < dct4_pkg::DIM; c++) begin
						blk_q[r][c] <= blk_q[r][(c+1)%dct4_pkg::DIM];
					end
				end
			end
		end

		// Accumulate first term, round and shift in the output on the second
		if (in_calc && step_q >= STEP_FIRST_ACC) begin
			if (!j_acc[0]) begin
				acc_q <= prod_s1;
			end else begin
				for (int k = 0; k < dct4_pkg::DIM; k++) begin
					if (dct4_pkg::DIM_W'(k) == k_out) begin
						for (int i = 0; i < dct4_pkg::DIM - 1; i++) begin
							if (row_pass) begin
								res_q[k][i] <= res_q[k][i+1];
							end else begin
								mid_q[k][i] <= mid_q[k][i+1];
							end
						end
						if (row_pass) begin
							res_q[k][dct4_pkg::DIM-1] <= y;
						end else begin
							mid_q[k][dct4_pkg::DIM-1] <= y;
						end
					end
				end
			end
		end

		// Emission chain in position order
		if (out_acc) begin
			for (int i = 0; i < dct4_pkg::BLK_N - 1; i++) begin
				res_q[i/dct4_pkg::DIM][i%dct4_pkg::DIM] <=
					res_q[(i+1)/dct4_pkg::DIM][(i+1)%dct4_pkg::DIM];
			end
		end
	end

	// Positions climb by one within a block
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !coefs.last |=> coefs.valid
			&& coefs.position == $past(coefs.position) + 1'b1)
		else $error("coefficient position skipped");

	// Taking a block starts a fresh column pass
	a_pop_start: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> in_calc && step_q == STEP_LOAD && bfly_q == '0)
		else $error("block taken without starting the transform");

	// Last butterfly hands over to emission at position zero
	a_calc_done: assert property (@(posedge clk) disable iff (!arst_n)
		in_calc && step_q == STEP_LAST && bfly_q == BFLY_LAST
			|=> coefs.valid && coefs.position == '0)
		else $error("emission did not follow the row pass");

	// Nothing follows the last coefficient of a block
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && coefs.last |=> !coefs.valid)
		else $error("request after last coefficient");

endmodule

FILE: tb/dct4x4_forward_transform_test.sv
// Testbench for the 4x4 forward DCT: sample stimulus, coefficient prediction and checking.
`timescale 1ns / 1ps

module dct4x4_forward_transform_test;

	localparam int RESET_CYCLES = 11;
	localparam int SETTLE_CYCLES = 120;   // beyond the first-result latency
	localparam int STALL_LIMIT = 2000;    // cycles with no request moving on either side
	localparam int RANDOM_BLOCKS = 1;
	localparam int BURST_BLOCKS = 3;

	// How the samples of a random block are drawn
	typedef enum logic [1:0] {
		FILL_RANDOM,
		FILL_FLAT_EXTREME,
		FILL_CHECKER,
		FILL_SMALL
	} block_fill_t;

	typedef struct {
		logic signed [dct4_pkg::COEF_W-1:0] coefficient;
		logic [dct4_pkg::POS_W-1:0]         position;
		logic                               last;
	} coef_req_t;

	logic clk = 1'b0;
	logic arst_n;

	dct4_sample_if samples();
	dct4_coef_if   coefs();

	dct4x4_forward_transform u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples),
		.coefs  (coefs)
	);

	// Block being collected, and coefficients still owed by the block
	logic signed [dct4_pkg::SAMPLE_W-1:0] held[dct4_pkg::BLK_N];
	int                                   held_count = 0;
	coef_req_t                            coef_expect[$];

	int  errors = 0;
	int  coefs_seen = 0;
	int  idle_cycles = 0;
	int  stall_left = 0;
	bit  src_steady = 1'b0;
	bit  sink_steady = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Add half, then arithmetic shift: floor rounding by 2^13
	function automatic longint descale13(input longint v);
		return (v + 64'sd4096) >>> 13;
	endfunction

	// 4-point integer butterfly DCT
	function automatic void butterfly4(input longint x0, input longint x1, input longint x2,
			input longint x3, output longint y[4]);
		longint ka;
		longint kb;
		longint kc;
		longint s0;
		longint s1;
		longint d0;
		longint d1;
		ka = longint'(dct4_pkg::K_A);
		kb = longint'(dct4_pkg::K_B);
		kc = longint'(dct4_pkg::K_C);
		s0 = x0 + x3;
		s1 = x1 + x2;
		d0 = x1 - x2;
		d1 = x0 - x3;
		y[0] = descale13(ka * s0 + ka * s1);
		y[2] = descale13(ka * s0 - ka * s1);
		y[1] = descale13(kb * d0 + kc * d1);
		y[3] = descale13(kb * d1 - kc * d0);
	endfunction

	// Column pass on samples scaled by 4, row pass, then queue in transposed order
	task automatic predict_block();
		longint mid[dct4_pkg::BLK_N];
		longint res[dct4_pkg::BLK_N];
		longint y[4];
		coef_req_t item;
		for (int c = 0; c < dct4_pkg::DIM; c++) begin
			butterfly4(4 * longint'(held[c]), 4 * longint'(held[4 + c]),
				4 * longint'(held[8 + c]), 4 * longint'(held[12 + c]), y);
			for (int r = 0; r < dct4_pkg::DIM; r++)
				mid[r * 4 + c] = y[r];
		end
		for (int r = 0; r < dct4_pkg::DIM; r++) begin
			butterfly4(mid[r * 4], mid[r * 4 + 1], mid[r * 4 + 2], mid[r * 4 + 3], y);
			for (int c = 0; c < dct4_pkg::DIM; c++)
				res[c * 4 + r] = y[c];
		end
		for (int k = 0; k < dct4_pkg::BLK_N; k++) begin
			item.coefficient = dct4_pkg::COEF_W'(res[k]);
			item.position    = dct4_pkg::POS_W'(k);
			item.last        = (k == dct4_pkg::BLK_N - 1);
			coef_expect.push_back(item);
		end
	endtask

	// Send one sample; entered at a falling edge, returns at a falling edge with valid held
	task automatic push_sample(input logic signed [dct4_pkg::SAMPLE_W-1:0] s);
		int gap;
		gap = src_steady ? 0 : pick_gap();
		if (gap != 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples.valid  <= 1'b1;
		samples.sample <= s;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		held[held_count] = s;
		held_count++;
		if (held_count == dct4_pkg::BLK_N) begin
			predict_block();
			held_count = 0;
		end
		@(negedge clk);
	endtask

	// Hold the sender off until every owed coefficient has come back
	task automatic await_results();
		samples.valid <= 1'b0;
		@(negedge clk);
		while (coef_expect.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [dct4_pkg::SAMPLE_W-1:0] draw_sample(
			input block_fill_t fill, input int idx, input bit polarity);
		logic signed [dct4_pkg::SAMPLE_W-1:0] hi;
		logic signed [dct4_pkg::SAMPLE_W-1:0] lo;
		hi = 16'sh7FFF;
		lo = 16'sh8000;
		case (fill)
			FILL_FLAT_EXTREME: return polarity ? hi : lo;
			FILL_CHECKER: return ((((idx >> 2) + idx) & 1) ^ polarity) ? hi : lo;
			FILL_SMALL: return dct4_pkg::SAMPLE_W'($urandom_range(0, 16)) - 16'sd8;
			default: return dct4_pkg::SAMPLE_W'($urandom());
		endcase
	endfunction

	task automatic send_block(input block_fill_t fill);
		bit polarity;
		polarity = $urandom_range(0, 1);
		for (int i = 0; i < dct4_pkg::BLK_N; i++)
			push_sample(draw_sample(fill, i, polarity));
	endtask

	// Directed block: full-scale values of both signs, zero and the unit values
	task automatic test_extreme_block();
		logic signed [dct4_pkg::SAMPLE_W-1:0] pattern[dct4_pkg::BLK_N];
		pattern = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
			16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
			16'sh0000, -16'sd1, 16'sd1, 16'sh0000,
			16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000};
		for (int i = 0; i < dct4_pkg::BLK_N; i++)
			push_sample(pattern[i]);
	endtask

	// A partial block must survive the sender going quiet until all results are out
	task automatic test_partial_block_hold();
		int split;
		split = $urandom_range(1, dct4_pkg::BLK_N - 1);
		for (int i = 0; i < split; i++)
			push_sample(dct4_pkg::SAMPLE_W'($urandom()));
		await_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		for (int i = split; i < dct4_pkg::BLK_N; i++)
			push_sample(dct4_pkg::SAMPLE_W'($urandom()));
	endtask

	task automatic test_random_blocks();
		for (int b = 0; b < RANDOM_BLOCKS; b++)
			send_block(block_fill_t'($urandom_range(0, 3)));
	endtask

	// Back-to-back samples fill the block queue while the sink still stalls
	task automatic test_full_rate_burst();
		src_steady = 1'b1;
		for (int b = 0; b < BURST_BLOCKS; b++)
			send_block(block_fill_t'($urandom_range(0, 3)));
		src_steady = 1'b0;
	endtask

	// Both sides at full rate
	task automatic test_no_idle_stretch();
		src_steady  = 1'b1;
		sink_steady = 1'b1;
		send_block(FILL_RANDOM);
		await_results();
		src_steady  = 1'b0;
		sink_steady = 1'b0;
	endtask

	// Coefficient sink: random stalls, driven at the falling edge
	always @(negedge clk) begin
		if (stall_left != 0) begin
			coefs.ready <= 1'b0;
			stall_left--;
		end else begin
			coefs.ready <= 1'b1;
			if (!sink_steady && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	// Compare each coefficient request with the oldest prediction
	always @(posedge clk) begin
		coef_req_t want;
		if (arst_n && coefs.valid && coefs.ready) begin
			if (coef_expect.size() == 0) begin
				report_mismatch($sformatf("unexpected coefficient %0d at position %0d",
					coefs.coefficient, coefs.position));
			end else begin
				want = coef_expect.pop_front();
				if (coefs.coefficient !== want.coefficient)
					report_mismatch($sformatf("result %0d coefficient got %0d expected %0d",
						coefs_seen, coefs.coefficient, want.coefficient));
				if (coefs.position !== want.position)
					report_mismatch($sformatf("result %0d position got %0d expected %0d",
						coefs_seen, coefs.position, want.position));
				if (coefs.last !== want.last)
					report_mismatch($sformatf("result %0d last got %b expected %b",
						coefs_seen, coefs.last, want.last));
			end
			coefs_seen++;
		end
	end

	// Watchdog on cycles where no request moves
	always @(posedge clk) begin
		if ((samples.valid && samples.ready) || (coefs.valid && coefs.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d idle cycles, %0d results owed", idle_cycles,
				coef_expect.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		samples.valid  = 1'b0;
		samples.sample = '0;
		coefs.ready    = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_extreme_block();
		test_partial_block_hold();
		test_random_blocks();
		test_full_rate_burst();
		test_no_idle_stretch();

		await_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: dct4x4_forward_transform.f
hw/rtl/dct4_pkg.sv
hw/rtl/dct4_if.sv
hw/rtl/dct4_front.sv
hw/rtl/dct4_queue.sv
hw/rtl/dct4_back.sv
hw/rtl/dct4x4_forward_transform.sv
tb/dct4x4_forward_transform_test.sv
